// ===== rtl/crcrr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcrr_pkg
// shared codes, queue entry type and crc helper for the request/response framer
// ----------------------------------------------------------------------------
package crcrr_pkg;

	localparam logic [1:0] ACT_START   = 2'd0;
	localparam logic [1:0] ACT_PAYLOAD = 2'd1;
	localparam logic [1:0] ACT_LINK    = 2'd2;
	localparam logic [1:0] ACT_TICK    = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_RX     = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_BAD_CMD  = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE = 3'd3;
	localparam logic [2:0] ST_BAD_CRC  = 3'd4;

	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RST = 16'd200;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// all result words of one input word share kind and status
	typedef struct packed {
		logic [1:0]      kind;
		logic [2:0]      status;
		logic [2:0]      count;
		logic [3:0][7:0] bytes;
	} crcrr_entry_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crcrr_front.sv =====
// ----------------------------------------------------------------------------
// crcrr_front
// accepts input words, runs the exchange state machine, queues result groups
// ----------------------------------------------------------------------------
module crcrr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic [15:0]           timeout_ticks,
	input  logic                  q_full,
	output logic                  push,
	output crcrr_pkg::crcrr_entry_t push_entry
);
	import crcrr_pkg::*;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_SEND  = 7'b0000010,
		PH_CMD   = 7'b0000100,
		PH_LEN   = 7'b0001000,
		PH_DATA  = 7'b0010000,
		PH_CRCLO = 7'b0100000,
		PH_CRCHI = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  reqlen_q, reqlen_d;
	logic [7:0]  rsplen_q, rsplen_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  lowrx_q, lowrx_d;
	logic [15:0] tick_q, tick_d;

	logic [1:0]  action;
	logic [7:0]  command, request_length, response_length, data_byte;
	logic        accept;
	logic [15:0] crc_fed;
	logic [7:0]  cnt_inc;
	crcrr_entry_t ent;

	assign action          = s_tuser;
	assign command         = s_tdata[7:0];
	assign request_length  = s_tdata[15:8];
	assign response_length = s_tdata[23:16];
	assign data_byte       = s_tdata[31:24];

	assign s_tready   = !q_full;
	assign accept     = s_tvalid && s_tready;
	assign crc_fed    = crc_feed(crc_q, data_byte);
	assign cnt_inc    = cnt_q + 8'd1;
	assign push_entry = ent;

	always_comb begin
		phase_d  = phase_q;
		cmd_d    = cmd_q;
		reqlen_d = reqlen_q;
		rsplen_d = rsplen_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		lowrx_d  = lowrx_q;
		tick_d   = tick_q;
		push     = 1'b0;
		ent      = '0;
		if (accept) begin
			unique case (action)
				ACT_START: begin
					cmd_d         = command;
					reqlen_d      = request_length;
					rsplen_d      = response_length;
					crc_d         = CRC_INIT;
					cnt_d         = 8'd0;
					tick_d        = 16'd0;
					lowrx_d       = 8'd0;
					push          = 1'b1;
					ent.kind      = KIND_TX;
					ent.bytes[0]  = command;
					ent.bytes[1]  = request_length;
					if (request_length == 8'd0) begin
						ent.bytes[2] = CRC_INIT[7:0];
						ent.bytes[3] = CRC_INIT[15:8];
						ent.count    = 3'd4;
						phase_d      = PH_CMD;
					end else begin
						ent.count    = 3'd2;
						phase_d      = PH_SEND;
					end
				end
				ACT_PAYLOAD: begin
					if (phase_q == PH_SEND) begin
						push         = 1'b1;
						ent.kind     = KIND_TX;
						ent.bytes[0] = data_byte;
						crc_d        = crc_fed;
						cnt_d        = cnt_inc;
						if (cnt_inc == reqlen_q) begin
							ent.bytes[1] = crc_fed[7:0];
							ent.bytes[2] = crc_fed[15:8];
							ent.count    = 3'd3;
							crc_d        = CRC_INIT;
							cnt_d        = 8'd0;
							tick_d       = 16'd0;
							phase_d      = PH_CMD;
						end else begin
							ent.count    = 3'd1;
						end
					end
				end
				ACT_LINK: begin
					unique case (phase_q)
						PH_CMD: begin
							if (data_byte != cmd_q) begin
								push       = 1'b1;
								ent.kind   = KIND_STATUS;
								ent.status = ST_BAD_CMD;
								ent.count  = 3'd1;
								phase_d    = PH_IDLE;
							end else begin
								phase_d    = PH_LEN;
							end
						end
						PH_LEN: begin
							if (data_byte != rsplen_q) begin
								push       = 1'b1;
								ent.kind   = KIND_STATUS;
								ent.status = ST_BAD_SIZE;
								ent.count  = 3'd1;
								phase_d    = PH_IDLE;
							end else if (rsplen_q == 8'd0) begin
								phase_d    = PH_CRCLO;
							end else begin
								phase_d    = PH_DATA;
							end
						end
						PH_DATA: begin
							push         = 1'b1;
							ent.kind     = KIND_RX;
							ent.bytes[0] = data_byte;
							ent.count    = 3'd1;
							crc_d        = crc_fed;
							cnt_d        = cnt_inc;
							if (cnt_inc == rsplen_q) begin
								phase_d = PH_CRCLO;
							end
						end
						PH_CRCLO: begin
							lowrx_d = data_byte;
							phase_d = PH_CRCHI;
						end
						PH_CRCHI: begin
							push       = 1'b1;
							ent.kind   = KIND_STATUS;
							ent.count  = 3'd1;
							ent.status = ({data_byte, lowrx_q} == crc_q) ? ST_OK : ST_BAD_CRC;
							phase_d    = PH_IDLE;
						end
						default: begin
						end
					endcase
				end
				ACT_TICK: begin
					if (phase_q != PH_IDLE && phase_q != PH_SEND) begin
						if (tick_q >= timeout_ticks) begin
							push       = 1'b1;
							ent.kind   = KIND_STATUS;
							ent.status = ST_TIMEOUT;
							ent.count  = 3'd1;
							phase_d    = PH_IDLE;
						end else begin
							tick_d     = tick_q + 16'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cmd_q    <= 8'd0;
			reqlen_q <= 8'd0;
			rsplen_q <= 8'd0;
			cnt_q    <= 8'd0;
			crc_q    <= CRC_INIT;
			lowrx_q  <= 8'd0;
			tick_q   <= 16'd0;
		end else begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			reqlen_q <= reqlen_d;
			rsplen_q <= rsplen_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			lowrx_q  <= lowrx_d;
			tick_q   <= tick_d;
		end
	end

endmodule

// ===== rtl/crcrr_queue.sv =====
// ----------------------------------------------------------------------------
// crcrr_queue
// short fifo of result groups between front and back end
// ----------------------------------------------------------------------------
module crcrr_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcrr_pkg::crcrr_entry_t push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output crcrr_pkg::crcrr_entry_t pop_entry
);
	import crcrr_pkg::*;

	crcrr_entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_q, rd_q;
	logic [QPTR_W:0]         fill_q;

	assign full      = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/crcrr_back.sv =====
// ----------------------------------------------------------------------------
// crcrr_back
// takes result groups from the queue and sends them one word per cycle while m_tready is high
// ----------------------------------------------------------------------------
module crcrr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_not_empty,
	input  crcrr_pkg::crcrr_entry_t q_entry,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             m_tdata,
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);
	import crcrr_pkg::*;

	logic         busy_q;
	crcrr_entry_t cur_q;
	logic [1:0]   idx_q;
	logic         last;
	logic         done;

	assign last     = ({1'b0, idx_q} == (cur_q.count - 3'd1));
	assign done     = busy_q && m_tready && last;
	assign pop      = q_not_empty && (!busy_q || done);

	assign m_tvalid = busy_q;
	assign m_tdata  = {5'b00000, cur_q.status, cur_q.bytes[idx_q]};
	assign m_tuser  = cur_q.kind;
	assign m_tlast  = last;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && m_tready) begin
			idx_q  <= idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/crc16_request_response_framer.sv =====
// ----------------------------------------------------------------------------
// crc16_request_response_framer
// framed request/response master with crc-16/ccitt-false on both directions
// ----------------------------------------------------------------------------
//   channel   dir  handshake            contents
//   s_*       in   s_tvalid/s_tready    tuser action, tdata cmd/lengths/byte
//   m_*       out  m_tvalid/m_tready    tuser kind, tdata byte/status, tlast
//   cfg_*     in   cfg_wen              timeout_ticks
//
// an input word is taken every cycle while the four-group queue has room
// each word yields zero to four result words, sent one per cycle by the
// back end while m_tready is high
// arst_n clears the exchange state and queue and sets timeout to 200 at once
// a stalled output fills the queue, and then the front stops taking words
// ----------------------------------------------------------------------------
module crc16_request_response_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // command, request_length, response_length, data_byte
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_byte, status, zero pad
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);
	import crcrr_pkg::*;

	logic [15:0]  timeout_q;
	logic         push, pop, q_full, q_not_empty;
	crcrr_entry_t push_entry, pop_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wen) begin
			timeout_q <= cfg_wdata;
		end
	end

	crcrr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.timeout_ticks (timeout_q),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	crcrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.pop_entry  (pop_entry)
	);

	crcrr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_entry     (pop_entry),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== sim/crcrr_checker.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// crcrr_checker
// watches the input, config and result channels of the framer, predicts
// every result word from the accepted input words and compares them in order
// ----------------------------------------------------------------------------
module crcrr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // command, request_length, response_length, data_byte
	input  logic [1:0]  s_tuser,   // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // out_byte, status, zero pad
	input  logic [1:0]  m_tuser,   // kind
	input  logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	output int          errors,
	output int          pending
);
	import crcrr_pkg::*;

	localparam logic [15:0] CCITT_POLY     = 16'h1021;
	localparam logic [15:0] CCITT_SEED     = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_AT_RST = 16'd200;

	typedef enum logic [2:0] {
		XS_IDLE,
		XS_SEND,
		XS_ECHO_CMD,
		XS_ECHO_LEN,
		XS_BODY,
		XS_CRC_LO,
		XS_CRC_HI
	} xchg_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data;
		logic        last;
	} result_word_t;

	result_word_t expected_words[$];
	result_word_t burst[$];   // words caused by the current input word
	result_word_t got, want;
	xchg_state_t  state;
	logic [15:0]  timeout_lim;
	logic [7:0]   cmd_r, req_len_r, rsp_len_r, count_r, crc_lo_r;
	logic [15:0]  crc_r, ticks_r;
	int           fails;

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
		end
		return crc;
	endfunction

	function automatic void add_result(input logic [1:0] kind, input logic [7:0] b,
			input logic [2:0] st);
		burst.push_back('{kind: kind, data: {5'b0, st, b}, last: 1'b0});
	endfunction

	// request crc low byte first, then wait for the echo
	function automatic void send_crc();
		add_result(KIND_TX, crc_r[7:0], ST_OK);
		add_result(KIND_TX, crc_r[15:8], ST_OK);
		crc_r   = CCITT_SEED;
		count_r = '0;
		ticks_r = '0;
		state   = XS_ECHO_CMD;
	endfunction

	function automatic void end_exchange(input logic [2:0] st);
		state = XS_IDLE;
		add_result(KIND_STATUS, 8'h00, st);
	endfunction

	function automatic void frame_results(input logic [1:0] act, input logic [31:0] word);
		logic [7:0] d;
		d = word[31:24];
		burst.delete();
		case (act)
			ACT_START: begin
				cmd_r     = word[7:0];
				req_len_r = word[15:8];
				rsp_len_r = word[23:16];
				crc_r     = CCITT_SEED;
				count_r   = '0;
				ticks_r   = '0;
				crc_lo_r  = '0;
				add_result(KIND_TX, cmd_r, ST_OK);
				add_result(KIND_TX, req_len_r, ST_OK);
				if (req_len_r == 8'd0) begin
					send_crc();
				end else begin
					state = XS_SEND;
				end
			end
			ACT_PAYLOAD: begin
				if (state == XS_SEND) begin
					add_result(KIND_TX, d, ST_OK);
					crc_r   = crc16_next(crc_r, d);
					count_r = count_r + 8'd1;
					if (count_r == req_len_r) begin
						send_crc();
					end
				end
			end
			ACT_LINK: begin
				case (state)
					XS_ECHO_CMD: begin
						if (d != cmd_r) begin
							end_exchange(ST_BAD_CMD);
						end else begin
							state = XS_ECHO_LEN;
						end
					end
					XS_ECHO_LEN: begin
						if (d != rsp_len_r) begin
							end_exchange(ST_BAD_SIZE);
						end else begin
							state = (rsp_len_r == 8'd0) ? XS_CRC_LO : XS_BODY;
						end
					end
					XS_BODY: begin
						add_result(KIND_RX, d, ST_OK);
						crc_r   = crc16_next(crc_r, d);
						count_r = count_r + 8'd1;
						if (count_r == rsp_len_r) begin
							state = XS_CRC_LO;
						end
					end
					XS_CRC_LO: begin
						crc_lo_r = d;
						state    = XS_CRC_HI;
					end
					XS_CRC_HI: begin
						end_exchange(({d, crc_lo_r} == crc_r) ? ST_OK : ST_BAD_CRC);
					end
					default: begin
					end
				endcase
			end
			default: begin
				// ticks only count while the response is awaited
				if (state != XS_IDLE && state != XS_SEND) begin
					if (ticks_r >= timeout_lim) begin
						end_exchange(ST_TIMEOUT);
					end else begin
						ticks_r = ticks_r + 16'd1;
					end
				end
			end
		endcase
		if (burst.size() > 0) begin
			burst[burst.size() - 1].last = 1'b1;
			foreach (burst[i]) expected_words.push_back(burst[i]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state       = XS_IDLE;
			timeout_lim = TIMEOUT_AT_RST;
			cmd_r       = '0;
			req_len_r   = '0;
			rsp_len_r   = '0;
			count_r     = '0;
			crc_r       = CCITT_SEED;
			crc_lo_r    = '0;
			ticks_r     = '0;
			fails       = 0;
			expected_words.delete();
			pending <= 0;
			errors  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{kind: m_tuser, data: m_tdata, last: m_tlast};
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: unexpected word kind %0d data %04h last %0b",
						$time, got.kind, got.data, got.last);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t: expected kind %0d data %04h last %0b, got kind %0d data %04h last %0b",
							$time, want.kind, want.data, want.last,
							got.kind, got.data, got.last);
					end
				end
			end
			if (cfg_wen) begin
				timeout_lim = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				frame_results(s_tuser, s_tdata);
			end
			pending <= expected_words.size();
			errors  <= fails;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb
// drives request/response exchanges into the framer with random idling on
// both channels and across several timeout settings; the checker predicts
// and compares every result word
// ----------------------------------------------------------------------------
module tb;
	import crcrr_pkg::*;

	localparam int LIMIT     = 200000;
	localparam int DRAIN_CYC = 16;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 35;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = ACT_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_wen   = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          errors;
	int          pending;
	int          cycles     = 0;
	int          words_sent = 0;
	bit          src_idle   = 1'b1;
	bit          sink_idle  = 1'b1;

	crc16_request_response_framer u_top (.*);

	crcrr_checker u_chk (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAIL crc16_request_response_framer");
			$finish;
		end
	end

	initial begin : sink
		int stall;
		forever begin
			stall = sink_idle ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		crc ^= {b, 8'h00};
		repeat (8) crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
		return crc;
	endfunction

	function automatic bit bail();
		return $urandom_range(0, 39) == 0;
	endfunction

	function automatic logic [7:0] pick_len();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 24)) : 8'($urandom_range(0, 6));
	endfunction

	task automatic put_word(input logic [1:0] act, input logic [7:0] cmd, rq, rs, b);
		int gap;
		gap = src_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {b, rs, rq, cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic put_start(input logic [7:0] cmd, rq, rs);
		words_sent++;
		put_word(ACT_START, cmd, rq, rs, 8'($urandom));
	endtask

	task automatic put_byte(input logic [1:0] act, input logic [7:0] b);
		words_sent++;
		put_word(act, 8'($urandom), 8'($urandom), 8'($urandom), b);
	endtask

	task automatic put_noise();
		put_word(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic put_ticks();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) put_byte(ACT_TICK, 8'($urandom));
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic run_exchange();
		logic [7:0]  cmd, rq, rs, b;
		logic [15:0] crc;
		// start with arbitrary lengths, abandoned by the next start
		if ($urandom_range(0, 11) == 0) begin
			put_start(8'($urandom), 8'($urandom), 8'($urandom));
			repeat ($urandom_range(0, 3)) put_byte(ACT_PAYLOAD, 8'($urandom));
			return;
		end
		cmd = 8'($urandom);
		rq  = pick_len();
		rs  = pick_len();
		if ($urandom_range(0, 9) == 0) put_noise();
		put_start(cmd, rq, rs);
		for (int i = 0; i < rq; i++) begin
			if (bail()) return;
			if ($urandom_range(0, 7) == 0) put_noise();
			put_byte(ACT_PAYLOAD, 8'($urandom));
		end
		put_ticks();
		if (bail()) return;
		if ($urandom_range(0, 9) == 0) begin
			put_byte(ACT_LINK, cmd ^ 8'($urandom_range(1, 255)));
			return;
		end
		put_byte(ACT_LINK, cmd);
		put_ticks();
		if ($urandom_range(0, 9) == 0) begin
			put_byte(ACT_LINK, rs ^ 8'($urandom_range(1, 255)));
			return;
		end
		put_byte(ACT_LINK, rs);
		crc = 16'hFFFF;
		for (int i = 0; i < rs; i++) begin
			put_ticks();
			if (bail()) return;
			b = 8'($urandom);
			put_byte(ACT_LINK, b);
			crc = crc16_byte(crc, b);
		end
		put_ticks();
		if ($urandom_range(0, 7) == 0) crc ^= 16'($urandom_range(1, 65535));
		put_byte(ACT_LINK, crc[7:0]);
		put_ticks();
		put_byte(ACT_LINK, crc[15:8]);
		if ($urandom_range(0, 9) == 0) put_noise();
	endtask

	initial begin : stimulus
		logic [15:0] limits [PHASES];
		limits    = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd200, 16'd1};
		limits[5] = 16'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing in flight: all ignored
		put_byte(ACT_LINK, 8'h00);
		put_byte(ACT_TICK, 8'hFF);
		put_byte(ACT_PAYLOAD, 8'hFF);
		// empty request, empty response
		put_start(8'hFF, 8'h00, 8'h00);
		put_byte(ACT_LINK, 8'hFF);
		put_byte(ACT_LINK, 8'h00);
		put_byte(ACT_LINK, 8'hFF);
		put_byte(ACT_LINK, 8'hFF);
		// tick during send, then wrong echoed command
		put_start(8'h00, 8'h01, 8'hFF);
		put_byte(ACT_TICK, 8'h00);
		put_byte(ACT_PAYLOAD, 8'hFF);
		put_byte(ACT_LINK, 8'h5A);
		// link word during send, then wrong size
		put_start(8'hA5, 8'h02, 8'h01);
		put_byte(ACT_PAYLOAD, 8'h00);
		put_byte(ACT_LINK, 8'hA5);
		put_byte(ACT_PAYLOAD, 8'h80);
		put_byte(ACT_LINK, 8'hA5);
		put_byte(ACT_LINK, 8'h02);
		// restart mid request, then bad response crc
		put_start(8'h3C, 8'hFF, 8'hFF);
		put_byte(ACT_PAYLOAD, 8'h12);
		put_start(8'h7E, 8'h00, 8'h01);
		put_byte(ACT_LINK, 8'h7E);
		put_byte(ACT_LINK, 8'h01);
		put_byte(ACT_LINK, 8'hC3);
		put_byte(ACT_LINK, 8'h00);
		put_byte(ACT_LINK, 8'h00);
		drain();

		words_sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			src_idle  = (p != 3) && ($urandom_range(0, 3) != 0);
			sink_idle = (p != 3) && ($urandom_range(0, 3) != 0);
			set_timeout(limits[p]);
			while (words_sent < (p + 1) * PER_PHASE) run_exchange();
			drain();
		end

		if (errors == 0) begin
			$display("PASS crc16_request_response_framer");
		end else begin
			$display("FAIL crc16_request_response_framer");
		end
		$finish;
	end

endmodule
